[rtl/i2c_master_register_read_top_assert.svh]
// assertion macros used by the checker file of the i2c register read master
`ifndef I2C_MASTER_REGISTER_READ_TOP_ASSERT_SVH
`define I2C_MASTER_REGISTER_READ_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define I2CMRR_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define I2CMRR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/i2cmrr_pkg.sv]
// shared types and constants of the i2c register read master
`default_nettype none

package i2cmrr_pkg;

   // request opcodes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   // top bit of a byte on the wire
   localparam logic [7:0] MSB_MASK = 8'h80;

   // one tick of pin levels and status
   typedef struct packed {
      logic       scl_level;
      logic       sda_release;
      logic       byte_valid;
      logic [7:0] read_byte;
      logic       last_byte;
      logic       done_res;
      logic       nack_error;
      logic       busy_res;
   } i2cmrr_result_type;

endpackage

`default_nettype wire

[rtl/i2c_master_register_read_top.sv]
// I2C register read master: request channel, sequencer and registered result
// Each request is one bus delay tick. A read or write opcode taken while idle
// starts a transaction; each request returns the SCL/SDA drive for that tick,
// any finished read byte, and busy, done and address-NACK status. One request
// is accepted every clock cycle; its result appears from the output register
// on the following cycle. A new request is taken in the same cycle that the
// waiting result is collected, and the request side stalls while that result
// is held off. The sequencer's combinational next-tick logic sets the rate.
`default_nettype none

module i2c_master_register_read_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output wire logic       req_stall,
   input  wire logic [1:0] req_opcode,
   input  wire logic [7:0] req_dev_addr,
   input  wire logic [7:0] req_reg_addr,
   input  wire logic [7:0] req_read_length,
   input  wire logic       req_sda_in,
   output wire logic       rsp_valid,
   input  wire logic       rsp_stall,
   output wire logic       rsp_scl_level,
   output wire logic       rsp_sda_release,
   output wire logic       rsp_byte_valid,
   output wire logic [7:0] rsp_read_byte,
   output wire logic       rsp_last_byte,
   output wire logic       rsp_done_res,
   output wire logic       rsp_nack_error,
   output wire logic       rsp_busy_res
);
   import i2cmrr_pkg::*;

   logic              req_accept;
   i2cmrr_result_type step_result;
   logic              rsp_valid_ff;
   i2cmrr_result_type rsp_data_ff;

   // take a request whenever the output register is free or draining
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   i2cmrr_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .step_en         (req_accept),
      .req_opcode      (req_opcode),
      .req_dev_addr    (req_dev_addr),
      .req_reg_addr    (req_reg_addr),
      .req_read_length (req_read_length),
      .req_sda_in      (req_sda_in),
      .result          (step_result)
   );

   // output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_scl_level   = rsp_data_ff.scl_level;
   assign rsp_sda_release = rsp_data_ff.sda_release;
   assign rsp_byte_valid  = rsp_data_ff.byte_valid;
   assign rsp_read_byte   = rsp_data_ff.read_byte;
   assign rsp_last_byte   = rsp_data_ff.last_byte;
   assign rsp_done_res    = rsp_data_ff.done_res;
   assign rsp_nack_error  = rsp_data_ff.nack_error;
   assign rsp_busy_res    = rsp_data_ff.busy_res;

endmodule

`default_nettype wire

[rtl/i2cmrr_engine.sv]
// bus sequencer: holds the transaction state and works out one tick per request
`default_nettype none

module i2cmrr_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step_en,
   input  wire logic [1:0]                    req_opcode,
   input  wire logic [7:0]                    req_dev_addr,
   input  wire logic [7:0]                    req_reg_addr,
   input  wire logic [7:0]                    req_read_length,
   input  wire logic                          req_sda_in,
   output i2cmrr_pkg::i2cmrr_result_type      result
);
   import i2cmrr_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_START_A,
      PH_SEND_DEV,
      PH_ACK_DEV,
      PH_SEND_REG,
      PH_ACK_REG,
      PH_START_B,
      PH_SEND_DEVR,
      PH_ACK_DEVR,
      PH_READ,
      PH_MACK,
      PH_STOP,
      PH_STOP_ERR
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [1:0] tick_ff, tick_in;
   logic [2:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] left_ff, left_in;
   logic [7:0] dev_ff, dev_in;
   logic [7:0] regaddr_ff, regaddr_in;
   logic       mode_ff, mode_in;

   // next state and pin levels for this tick
   always_comb begin
      phase_type  ph;
      logic [1:0] tk;
      logic [2:0] bc;
      logic [7:0] sh;
      logic [7:0] bl;
      logic [7:0] sh_rd;
      logic [7:0] bl_dec;

      ph = phase_ff;
      tk = tick_ff;
      bc = bit_ff;
      sh = shift_ff;
      bl = left_ff;
      dev_in     = dev_ff;
      regaddr_in = regaddr_ff;
      mode_in    = mode_ff;

      // opcode taken only while idle, first start tick driven at once
      if (phase_ff == PH_IDLE && (req_opcode == OP_READ || req_opcode == OP_WRITE)) begin
         dev_in     = req_dev_addr;
         regaddr_in = req_reg_addr;
         bl         = req_read_length;
         mode_in    = (req_opcode == OP_READ);
         ph = PH_START_A;
         tk = 2'd0;
         bc = 3'd0;
         sh = 8'd0;
      end

      sh_rd  = {sh[6:0], req_sda_in};
      bl_dec = (bl != 8'd0) ? bl - 8'd1 : bl;

      phase_in = ph;
      tick_in  = tk;
      bit_in   = bc;
      shift_in = sh;
      left_in  = bl;
      result   = '0;
      result.scl_level   = 1'b1;
      result.sda_release = 1'b1;

      case (ph)
         PH_IDLE: begin
         end
         PH_START_A, PH_START_B: begin
            result.busy_res    = 1'b1;
            result.sda_release = (tk < 2'd2);
            if (tk == 2'd3) begin
               tick_in = 2'd0;
               bit_in  = 3'd0;
               if (ph == PH_START_A) begin
                  phase_in = PH_SEND_DEV;
                  shift_in = mode_in ? {dev_in[6:0], 1'b0} : dev_in;
               end else begin
                  phase_in = PH_SEND_DEVR;
                  shift_in = {dev_in[6:0], 1'b1};
               end
            end else begin
               tick_in = tk + 2'd1;
            end
         end
         PH_SEND_DEV, PH_SEND_REG, PH_SEND_DEVR: begin
            result.busy_res    = 1'b1;
            result.scl_level   = tk[0];
            result.sda_release = |(sh & MSB_MASK);
            if (tk != 2'd0) begin
               shift_in = {sh[6:0], 1'b0};
               tick_in  = 2'd0;
               if (bc == 3'd7) begin
                  bit_in = 3'd0;
                  case (ph)
                     PH_SEND_DEV: phase_in = PH_ACK_DEV;
                     PH_SEND_REG: phase_in = PH_ACK_REG;
                     default:     phase_in = PH_ACK_DEVR;
                  endcase
               end else begin
                  bit_in = bc + 3'd1;
               end
            end else begin
               tick_in = 2'd1;
            end
         end
         PH_ACK_DEV, PH_ACK_REG, PH_ACK_DEVR: begin
            result.busy_res  = 1'b1;
            result.scl_level = tk[0];
            if (tk != 2'd0) begin
               tick_in  = 2'd0;
               bit_in   = 3'd0;
               shift_in = 8'd0;
               case (ph)
                  PH_ACK_DEV: begin
                     // only a refused read address aborts
                     if (mode_in && req_sda_in) begin
                        phase_in = PH_STOP_ERR;
                     end else begin
                        phase_in = PH_SEND_REG;
                        shift_in = regaddr_in;
                     end
                  end
                  PH_ACK_REG: phase_in = mode_in ? PH_START_B : PH_STOP;
                  default:    phase_in = (bl == 8'd0) ? PH_STOP : PH_READ;
               endcase
            end else begin
               tick_in = 2'd1;
            end
         end
         PH_READ: begin
            result.busy_res  = 1'b1;
            result.scl_level = (tk != 2'd0);
            // sample the data line mid-high
            if (tk == 2'd2) begin
               shift_in = sh_rd;
               if (bc == 3'd7) begin
                  result.byte_valid = 1'b1;
                  result.read_byte  = sh_rd;
                  result.last_byte  = (bl <= 8'd1);
               end
            end
            if (tk == 2'd3) begin
               tick_in = 2'd0;
               if (bc == 3'd7) begin
                  bit_in   = 3'd0;
                  phase_in = PH_MACK;
               end else begin
                  bit_in = bc + 3'd1;
               end
            end else begin
               tick_in = tk + 2'd1;
            end
         end
         PH_MACK: begin
            result.busy_res    = 1'b1;
            result.scl_level   = tk[0];
            result.sda_release = (bl <= 8'd1);
            if (tk != 2'd0) begin
               left_in  = bl_dec;
               tick_in  = 2'd0;
               bit_in   = 3'd0;
               shift_in = 8'd0;
               phase_in = (bl_dec == 8'd0) ? PH_STOP : PH_READ;
            end else begin
               tick_in = 2'd1;
            end
         end
         PH_STOP, PH_STOP_ERR: begin
            result.busy_res    = 1'b1;
            result.scl_level   = (tk != 2'd0);
            result.sda_release = (tk >= 2'd2);
            if (tk >= 2'd2) begin
               result.done_res   = 1'b1;
               result.nack_error = (ph == PH_STOP_ERR);
               phase_in = PH_IDLE;
               tick_in  = 2'd0;
               bit_in   = 3'd0;
               shift_in = 8'd0;
            end else begin
               tick_in = tk + 2'd1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            tick_in  = 2'd0;
            bit_in   = 3'd0;
            shift_in = 8'd0;
         end
      endcase
   end

   // state advances once per accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         tick_ff    <= 2'd0;
         bit_ff     <= 3'd0;
         shift_ff   <= 8'd0;
         left_ff    <= 8'd0;
         dev_ff     <= 8'd0;
         regaddr_ff <= 8'd0;
         mode_ff    <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         tick_ff    <= tick_in;
         bit_ff     <= bit_in;
         shift_ff   <= shift_in;
         left_ff    <= left_in;
         dev_ff     <= dev_in;
         regaddr_ff <= regaddr_in;
         mode_ff    <= mode_in;
      end
   end

endmodule

`default_nettype wire

[rtl/i2cmrr_checker.sv]
// port-level checks of the i2c register read master, bound to the top level
`default_nettype none

`include "i2c_master_register_read_top_assert.svh"

module i2cmrr_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_scl_level,
   input wire logic       rsp_sda_release,
   input wire logic       rsp_byte_valid,
   input wire logic       rsp_done_res,
   input wire logic       rsp_nack_error,
   input wire logic       rsp_busy_res
);

   // a held result stays offered
   `I2CMRR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")

   // every accepted request yields a result next cycle
   `I2CMRR_ASSERT_NEXT(a_req_to_rsp, clock, reset, req_valid && !req_stall, rsp_valid, "accepted request gave no result")

   // a read byte only arrives inside a transaction
   `I2CMRR_ASSERT_IMPLY(a_byte_busy, clock, reset, rsp_valid && rsp_byte_valid, rsp_busy_res, "read byte outside a transaction")

   // completion is the stop tick with both lines released
   `I2CMRR_ASSERT_IMPLY(a_done_stop, clock, reset, rsp_valid && rsp_done_res, rsp_busy_res && rsp_scl_level && rsp_sda_release, "done without stop levels")

   // an address error is only flagged on completion
   `I2CMRR_ASSERT_IMPLY(a_err_done, clock, reset, rsp_valid && rsp_nack_error, rsp_done_res, "nack error without done")

endmodule

bind i2c_master_register_read_top i2cmrr_checker u_i2cmrr_checker (.*);

`default_nettype wire
